// ----- design/dhcp_option_parser_defines.svh -----
// Assertion macros shared by the DHCP option parser modules.
`ifndef DHCP_OPTION_PARSER_DEFINES_SVH
`define DHCP_OPTION_PARSER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define DOP_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define DOP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/dop_pkg.sv -----
// Shared types, codes and the option code table of the DHCP option parser.
`timescale 1ns / 1ps
package dop_pkg;

   // Default geometry of the vendor area.
   localparam int AREA_SIZE_DEF    = 64;
   localparam int FIRST_OFFSET_DEF = 4;

   // Depth of the result queue; ready stays high while fewer than two wait.
   localparam int RSP_DEPTH = 3;

   // Option codes on the wire.
   localparam logic [7:0] CODE_MASK   = 8'h01;
   localparam logic [7:0] CODE_ROUTER = 8'h03;
   localparam logic [7:0] CODE_DNS    = 8'h06;
   localparam logic [7:0] CODE_LEASE  = 8'h33;
   localparam logic [7:0] CODE_TYPE   = 8'h35;
   localparam logic [7:0] CODE_SERVER = 8'h36;
   localparam logic [7:0] CODE_END    = 8'hFF;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CODE = 2'd1,
      PH_LEN  = 2'd2,
      PH_VAL  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      OPT_MASK   = 3'd0,
      OPT_ROUTER = 3'd1,
      OPT_DNS    = 3'd2,
      OPT_LEASE  = 3'd3,
      OPT_TYPE   = 3'd4,
      OPT_SERVER = 3'd5
   } opt_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BOUNDS  = 2'd1,
      ST_LENGTH  = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef struct packed {
      logic    known;
      opt_type opt;
   } code_info_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  msg_type;
      logic [31:0] subnet_mask;
      logic [31:0] router_addr;
      logic [31:0] dns_addr;
      logic [31:0] lease_seconds;
      logic [31:0] server_id;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

   // Maps an option code to the value it loads.
   function automatic code_info_type code_lookup(input logic [7:0] code);
      code_info_type info;
      info.known = 1'b1;
      info.opt   = OPT_MASK;
      case (code)
         CODE_MASK:   info.opt = OPT_MASK;
         CODE_ROUTER: info.opt = OPT_ROUTER;
         CODE_DNS:    info.opt = OPT_DNS;
         CODE_LEASE:  info.opt = OPT_LEASE;
         CODE_TYPE:   info.opt = OPT_TYPE;
         CODE_SERVER: info.opt = OPT_SERVER;
         default:     info.known = 1'b0;
      endcase
      return info;
   endfunction

endpackage

// ----- design/dop_req_if.sv -----
// Byte channel into the DHCP option parser.
`timescale 1ns / 1ps
interface dop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opt_byte;
   logic       begin_req;

   modport source (output valid, output opt_byte, output begin_req, input ready);
   modport sink   (input valid, input opt_byte, input begin_req, output ready);
endinterface

// ----- design/dop_rsp_if.sv -----
// Result channel out of the DHCP option parser.
`timescale 1ns / 1ps
interface dop_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  msg_type;
   logic [31:0] subnet_mask;
   logic [31:0] router_addr;
   logic [31:0] dns_addr;
   logic [31:0] lease_seconds;
   logic [31:0] server_id;

   modport source (output valid, output status, output msg_type, output subnet_mask,
                   output router_addr, output dns_addr, output lease_seconds,
                   output server_id, input ready);
   modport sink   (input valid, input status, input msg_type, input subnet_mask,
                   input router_addr, input dns_addr, input lease_seconds,
                   input server_id, output ready);
endinterface

// ----- design/dhcp_option_parser.sv -----
// Top level of the byte-serial DHCP options parser.
// Takes one options byte per cycle while input ready is high; the byte that ends the packet
// passes the input register, then its result is pushed into the result queue.
// Input ready stays high while fewer than two results wait, so bytes stream back to back.
// Synchronous active-high reset returns the parser to idle, clears the learned values
// and empties the result queue.
`timescale 1ns / 1ps
module dhcp_option_parser #(
   parameter int AREA_SIZE    = dop_pkg::AREA_SIZE_DEF,
   parameter int FIRST_OFFSET = dop_pkg::FIRST_OFFSET_DEF
) (
   input logic       clock,
   input logic       reset,
   dop_req_if.sink   req_chan,
   dop_rsp_if.source rsp_chan
);
   import dop_pkg::*;

   push_type rsp_push;
   rsp_type  head;
   logic     room;
   logic     in_accept;

   // A byte transfers when the queue has room for its possible result.
   assign req_chan.ready = room;
   assign in_accept      = req_chan.valid && req_chan.ready;

   dop_parse_core #(
      .AREA_SIZE    (AREA_SIZE),
      .FIRST_OFFSET (FIRST_OFFSET)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_chan.opt_byte),
      .in_begin  (req_chan.begin_req),
      .rsp_push  (rsp_push)
   );

   dop_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (head)
   );

   // Result payload from the head of the queue.
   assign rsp_chan.status        = head.status;
   assign rsp_chan.msg_type      = head.msg_type;
   assign rsp_chan.subnet_mask   = head.subnet_mask;
   assign rsp_chan.router_addr   = head.router_addr;
   assign rsp_chan.dns_addr      = head.dns_addr;
   assign rsp_chan.lease_seconds = head.lease_seconds;
   assign rsp_chan.server_id     = head.server_id;

endmodule

// ----- design/dop_parse_core.sv -----
// Input register, option parsing state and learned value registers.
`timescale 1ns / 1ps
`include "dhcp_option_parser_defines.svh"
module dop_parse_core #(
   parameter int AREA_SIZE    = dop_pkg::AREA_SIZE_DEF,
   parameter int FIRST_OFFSET = dop_pkg::FIRST_OFFSET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   input  logic              in_begin,
   output dop_pkg::push_type rsp_push
);
   import dop_pkg::*;

   localparam int POS_W = $clog2(AREA_SIZE);
   localparam int SUM_W = ((POS_W > 8) ? POS_W : 8) + 1;
   localparam logic [SUM_W-1:0] AREA_L    = SUM_W'(AREA_SIZE);
   localparam logic [POS_W-1:0] START_POS = POS_W'(FIRST_OFFSET);

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_begin_ff;

   // Parsing state.
   phase_type   phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   opt_type     cur_opt_ff, cur_opt_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] dns_ff, dns_in;
   logic [31:0] lease_ff, lease_in;
   logic [31:0] server_ff, server_in;

   // Values as seen by the byte at hand; a start marker overrides the state.
   phase_type        cur_phase;
   logic [POS_W-1:0] cur_pos;
   logic [7:0]       cur_type;
   code_info_type    lookup;
   logic [SUM_W-1:0] pos_sum1;
   logic [SUM_W-1:0] len_sum;
   logic [2:0]       need;
   logic             len_ok;
   logic [31:0]      shifted;
   logic             emit;
   status_type       status;

   // Conditions watched by the assertions.
   logic             val_count_ok;
   logic             in_type_val;
   logic             restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_byte_ff  <= in_byte;
         in_begin_ff <= in_begin;
      end
   end

   assign cur_phase = in_begin_ff ? PH_CODE : phase_ff;
   assign cur_pos   = in_begin_ff ? START_POS : position_ff;
   assign cur_type  = in_begin_ff ? 8'd0 : type_ff;
   assign lookup    = code_lookup(in_byte_ff);
   assign pos_sum1  = SUM_W'(cur_pos) + SUM_W'(1);
   assign len_sum   = pos_sum1 + SUM_W'(in_byte_ff);
   assign need      = (cur_opt_ff == OPT_TYPE) ? 3'd1 : 3'd4;
   assign len_ok    = (in_byte_ff == {5'd0, need});
   assign shifted   = {value_ff[23:0], in_byte_ff};

   // Next phase and the decision to end the packet with a result.
   always_comb begin
      phase_in = phase_ff;
      emit     = 1'b0;
      status   = ST_OK;
      if (in_valid_ff) begin
         case (cur_phase)
            PH_CODE: begin
               if (in_byte_ff == CODE_END) begin
                  emit   = 1'b1;
                  status = ST_OK;
               end else if (!lookup.known) begin
                  emit   = 1'b1;
                  status = ST_UNKNOWN;
               end else if (pos_sum1 >= AREA_L) begin
                  emit   = 1'b1;
                  status = ST_BOUNDS;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (len_sum >= AREA_L) begin
                  emit   = 1'b1;
                  status = ST_BOUNDS;
               end else if (!len_ok) begin
                  emit   = 1'b1;
                  status = ST_LENGTH;
               end else begin
                  phase_in = PH_VAL;
               end
            end
            PH_VAL: begin
               if (bytes_left_ff == 3'd1) begin
                  phase_in = PH_CODE;
               end else begin
                  phase_in = PH_VAL;
               end
            end
            default: phase_in = phase_ff;
         endcase
         if (emit) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Position, value assembly and commit of finished values.
   always_comb begin
      position_in   = position_ff;
      cur_opt_in    = cur_opt_ff;
      bytes_left_in = bytes_left_ff;
      value_in      = value_ff;
      type_in       = type_ff;
      mask_in       = mask_ff;
      router_in     = router_ff;
      dns_in        = dns_ff;
      lease_in      = lease_ff;
      server_in     = server_ff;
      if (in_valid_ff) begin
         position_in = cur_pos;
         type_in     = cur_type;
         case (cur_phase)
            PH_CODE: begin
               if (lookup.known) begin
                  cur_opt_in = lookup.opt;
               end
               if (phase_in == PH_LEN) begin
                  position_in = cur_pos + POS_W'(1);
               end
            end
            PH_LEN: begin
               if (phase_in == PH_VAL) begin
                  bytes_left_in = need;
                  value_in      = 32'd0;
                  position_in   = cur_pos + POS_W'(1);
               end
            end
            PH_VAL: begin
               value_in      = shifted;
               position_in   = cur_pos + POS_W'(1);
               bytes_left_in = bytes_left_ff - 3'd1;
               if (bytes_left_ff == 3'd1) begin
                  case (cur_opt_ff)
                     OPT_MASK:   mask_in   = shifted;
                     OPT_ROUTER: router_in = shifted;
                     OPT_DNS:    dns_in    = shifted;
                     OPT_LEASE:  lease_in  = shifted;
                     OPT_TYPE:   type_in   = shifted[7:0];
                     default:    server_in = shifted;
                  endcase
               end
            end
            default: position_in = cur_pos;
         endcase
      end
   end

   // Result assembled from the values committed so far.
   always_comb begin
      rsp_push.valid              = emit;
      rsp_push.data.status        = status;
      rsp_push.data.msg_type      = cur_type;
      rsp_push.data.subnet_mask   = mask_ff;
      rsp_push.data.router_addr   = router_ff;
      rsp_push.data.dns_addr      = dns_ff;
      rsp_push.data.lease_seconds = lease_ff;
      rsp_push.data.server_id     = server_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         position_ff   <= '0;
         cur_opt_ff    <= OPT_MASK;
         bytes_left_ff <= 3'd0;
         value_ff      <= 32'd0;
         type_ff       <= 8'd0;
         mask_ff       <= 32'd0;
         router_ff     <= 32'd0;
         dns_ff        <= 32'd0;
         lease_ff      <= 32'd0;
         server_ff     <= 32'd0;
      end else begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         cur_opt_ff    <= cur_opt_in;
         bytes_left_ff <= bytes_left_in;
         value_ff      <= value_in;
         type_ff       <= type_in;
         mask_ff       <= mask_in;
         router_ff     <= router_in;
         dns_ff        <= dns_in;
         lease_ff      <= lease_in;
         server_ff     <= server_in;
      end
   end

   assign val_count_ok = (bytes_left_ff != 3'd0) && (bytes_left_ff <= 3'd4);
   assign in_type_val  = (phase_ff == PH_VAL) && (cur_opt_ff == OPT_TYPE);
   assign restart      = in_valid_ff && in_begin_ff;

   // A result always returns the parser to idle.
   `DOP_ASSERT_NEXT(a_idle_after_result, emit, phase_ff == PH_IDLE, "no idle after result")
   // A value field counts down from its length and never sits at zero.
   `DOP_ASSERT_ALWAYS(a_val_count, phase_ff != PH_VAL || val_count_ok, "bad value byte count")
   // The message type option carries one value byte.
   `DOP_ASSERT_ALWAYS(a_type_len, !in_type_val || bytes_left_ff == 3'd1, "bad type length")
   // A start marker clears the message type.
   `DOP_ASSERT_NEXT(a_begin_clears_type, restart, type_ff == 8'd0, "type not cleared")

endmodule

// ----- design/dop_rsp_fifo.sv -----
// Small result queue that parts the parser from the result channel.
`timescale 1ns / 1ps
`include "dhcp_option_parser_defines.svh"
module dop_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  dop_pkg::push_type push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output dop_pkg::rsp_type  out_data
);
   import dop_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RSP_DEPTH - 1);

   rsp_type          entries_ff [RSP_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // One item may still be in flight in the parser, so leave one slot spare.
   assign room      = (count_ff < CNT_W'(RSP_DEPTH - 1));

   // Pointer and fill count update.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
      end
      if (push.valid) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push.valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[tail_ff] <= push.data;
      end
   end

   `DOP_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(RSP_DEPTH), "queue count out of range")
   `DOP_ASSERT_ALWAYS(a_no_overflow, !push.valid || count_ff < CNT_W'(RSP_DEPTH), "overflow")
   `DOP_ASSERT_ALWAYS(a_empty_ptrs, count_ff != '0 || head_ff == tail_ff, "pointers split")

endmodule

// ----- test/tb_dhcp_option_parser.sv -----
// Self-checking testbench for the DHCP option parser: random option packets against a predictor.
`timescale 1ns / 1ps
module tb_dhcp_option_parser;
   import dop_pkg::*;

   localparam int AREA        = AREA_SIZE_DEF;
   localparam int FIRST       = FIRST_OFFSET_DEF;
   localparam int ADDR_LEN    = 4;
   localparam int TYPE_LEN    = 1;
   localparam int MAX_GAP     = 13;
   localparam int BYTE_GOAL   = 1250;
   localparam int QUIET_LIMIT = 3000;
   localparam int PRINT_CAP   = 100;

   // Tracks the parse of the options area and holds the summaries the block owes us.
   class dhcp_lease_scoreboard;
      phase_type   phase;
      opt_type     cur_opt;
      int unsigned position;
      int unsigned bytes_left;
      logic [31:0] value_shift;
      logic [7:0]  msg_type_seen;
      logic [31:0] mask_seen;
      logic [31:0] router_seen;
      logic [31:0] dns_seen;
      logic [31:0] lease_seen;
      logic [31:0] server_seen;
      rsp_type     pending_summaries[$];
      int          errors;
      int          status_count[4];

      // The block is reset once, so construction doubles as the reset state.
      function new();
         phase         = PH_IDLE;
         cur_opt       = OPT_MASK;
         position      = 0;
         bytes_left    = 0;
         value_shift   = '0;
         msg_type_seen = '0;
         mask_seen     = '0;
         router_seen   = '0;
         dns_seen      = '0;
         lease_seen    = '0;
         server_seen   = '0;
         errors        = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      // A packet ends: queue its summary and go idle until the next start.
      function void post_summary(status_type st);
         rsp_type s;
         s.status        = st;
         s.msg_type      = msg_type_seen;
         s.subnet_mask   = mask_seen;
         s.router_addr   = router_seen;
         s.dns_addr      = dns_seen;
         s.lease_seconds = lease_seen;
         s.server_id     = server_seen;
         pending_summaries.push_back(s);
         status_count[st]++;
         phase = PH_IDLE;
      endfunction

      // Steps the parse by one transferred byte; returns 0 when the byte is ignored.
      function bit absorb_byte(logic [7:0] b, logic beg);
         int unsigned bv;
         int unsigned need;
         bit          known;
         bv = b;
         // A start marker always restarts, even in the middle of a packet.
         if (beg) begin
            position      = FIRST;
            phase         = PH_CODE;
            msg_type_seen = '0;
         end
         case (phase)
            PH_CODE: begin
               known = 1'b1;
               case (b)
                  CODE_MASK:   cur_opt = OPT_MASK;
                  CODE_ROUTER: cur_opt = OPT_ROUTER;
                  CODE_DNS:    cur_opt = OPT_DNS;
                  CODE_LEASE:  cur_opt = OPT_LEASE;
                  CODE_TYPE:   cur_opt = OPT_TYPE;
                  CODE_SERVER: cur_opt = OPT_SERVER;
                  CODE_END: begin
                     known = 1'b0;
                     post_summary(ST_OK);
                  end
                  default: begin
                     known = 1'b0;
                     post_summary(ST_UNKNOWN);
                  end
               endcase
               // A known code in the last byte has no room for its length.
               if (known) begin
                  if (position + 1 >= AREA) begin
                     post_summary(ST_BOUNDS);
                  end else begin
                     position++;
                     phase = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               need = (cur_opt == OPT_TYPE) ? TYPE_LEN : ADDR_LEN;
               // The area bound is checked ahead of the required length.
               if (position + 1 + bv >= AREA) begin
                  post_summary(ST_BOUNDS);
               end else if (bv != need) begin
                  post_summary(ST_LENGTH);
               end else begin
                  bytes_left  = need;
                  value_shift = '0;
                  position++;
                  phase = PH_VAL;
               end
            end
            PH_VAL: begin
               value_shift = {value_shift[23:0], b};
               position++;
               bytes_left--;
               // Values are committed only once their last byte is in.
               if (bytes_left == 0) begin
                  case (cur_opt)
                     OPT_MASK:   mask_seen     = value_shift;
                     OPT_ROUTER: router_seen   = value_shift;
                     OPT_DNS:    dns_seen      = value_shift;
                     OPT_LEASE:  lease_seen    = value_shift;
                     OPT_TYPE:   msg_type_seen = value_shift[7:0];
                     default:    server_seen   = value_shift;
                  endcase
                  phase = PH_CODE;
               end
            end
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
         end
      endtask

      // Compares one result transfer with the oldest predicted summary.
      task match_summary(rsp_type got);
         rsp_type want;
         if (pending_summaries.size() == 0) begin
            report_mismatch("result transfer while no packet summary is owed");
            return;
         end
         want = pending_summaries.pop_front();
         check_field("status", got.status, want.status);
         check_field("msg_type", got.msg_type, want.msg_type);
         check_field("subnet_mask", got.subnet_mask, want.subnet_mask);
         check_field("router_addr", got.router_addr, want.router_addr);
         check_field("dns_addr", got.dns_addr, want.dns_addr);
         check_field("lease_seconds", got.lease_seconds, want.lease_seconds);
         check_field("server_id", got.server_id, want.server_id);
      endtask

      function int pending();
         return pending_summaries.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   dop_req_if req_chan ();
   dop_rsp_if rsp_chan ();

   dhcp_option_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dhcp_lease_scoreboard board;
   int         parsed_bytes = 0;
   int         quiet_cycles = 0;
   int         packets_sent = 0;
   bit         steady       = 1'b0;
   logic [8:0] pkt[$];
   int         build_pos;
   bit         headless;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap before each transfer on either side; none during steady stretches.
   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [7:0] code_at(int idx);
      case (idx)
         0:       return CODE_MASK;
         1:       return CODE_ROUTER;
         2:       return CODE_DNS;
         3:       return CODE_LEASE;
         4:       return CODE_TYPE;
         default: return CODE_SERVER;
      endcase
   endfunction

   // Value bytes lean toward the all-zero and all-one extremes now and then.
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // The first byte of a packet carries the start marker unless it is stray noise.
   function automatic void push_byte(logic [7:0] b);
      pkt.push_back({(pkt.size() == 0) && !headless, b});
      build_pos++;
   endfunction

   function automatic void add_valid_option();
      logic [7:0] code;
      int         need;
      code = code_at($urandom_range(0, 5));
      need = (code == CODE_TYPE) ? TYPE_LEN : ADDR_LEN;
      push_byte(code);
      push_byte(8'(need));
      repeat (need) push_byte(random_byte());
   endfunction

   // Mostly well-formed packets, then broken ones, area-filling ones and stray bytes.
   task automatic build_packet();
      int         kind;
      int         need;
      logic [7:0] code;
      logic [7:0] len;
      pkt.delete();
      build_pos = FIRST;
      headless  = 1'b0;
      kind      = $urandom_range(0, 99);
      if (kind < 55) begin
         repeat ($urandom_range(0, 5)) add_valid_option();
         push_byte(CODE_END);
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(random_byte());
      end else if (kind < 80) begin
         repeat ($urandom_range(0, 3)) add_valid_option();
         code = code_at($urandom_range(0, 5));
         need = (code == CODE_TYPE) ? TYPE_LEN : ADDR_LEN;
         case ($urandom_range(0, 3))
            0: begin
               do code = random_byte();
               while (code == CODE_MASK || code == CODE_ROUTER || code == CODE_DNS ||
                      code == CODE_LEASE || code == CODE_TYPE || code == CODE_SERVER ||
                      code == CODE_END);
               push_byte(code);
            end
            1: begin
               push_byte(code);
               do len = 8'($urandom_range(0, 9)); while (len == need);
               push_byte(len);
            end
            2: begin
               push_byte(code);
               // Here build_pos is the position of the length byte.
               if ($urandom_range(0, 1) == 0) push_byte(8'(AREA - 1 - build_pos));
               else push_byte(8'($urandom_range(AREA - 1 - build_pos, 255)));
            end
            default: begin
               // Cut short; the next start marker aborts this packet.
               push_byte(code);
               if ($urandom_range(0, 3) != 0) begin
                  push_byte(8'(need));
                  repeat ($urandom_range(0, need - 1)) push_byte(random_byte());
               end
            end
         endcase
      end else if (kind < 95) begin
         while (build_pos < 55) add_valid_option();
         repeat ($urandom_range(0, 2)) add_valid_option();
         case ($urandom_range(0, 2))
            0:       push_byte(CODE_END);
            1:       push_byte(code_at($urandom_range(0, 5)));
            default: push_byte(random_byte());
         endcase
      end else begin
         headless = 1'b1;
         repeat ($urandom_range(1, 4)) push_byte(random_byte());
      end
   endtask

   // Presents one byte at the falling edge and holds it until its transfer.
   task automatic send_byte(input logic [7:0] b, input logic beg);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opt_byte  <= b;
      req_chan.begin_req <= beg;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Holds the input idle until every predicted result has transferred.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   // Result side: stall a random number of cycles before each transfer.
   initial begin : result_sink
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // Both channels are observed at the rising edge, inputs ahead of results.
   always @(posedge clock) begin : monitor
      rsp_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (board.absorb_byte(req_chan.opt_byte, req_chan.begin_req)) parsed_bytes++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status        = status_type'(rsp_chan.status);
            got.msg_type      = rsp_chan.msg_type;
            got.subnet_mask   = rsp_chan.subnet_mask;
            got.router_addr   = rsp_chan.router_addr;
            got.dns_addr      = rsp_chan.dns_addr;
            got.lease_seconds = rsp_chan.lease_seconds;
            got.server_id     = rsp_chan.server_id;
            board.match_summary(got);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Ends a hung run once no transfer has happened for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      board              = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.opt_byte  = 8'h00;
      req_chan.begin_req = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A stray byte while idle is dropped.
      send_byte(8'h00, 1'b0);
      // Full-scale mask, then a router value cut off by a new start.
      send_byte(CODE_MASK, 1'b1);   send_byte(8'(ADDR_LEN), 1'b0);
      send_byte(8'hFF, 1'b0);       send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);       send_byte(8'hFF, 1'b0);
      send_byte(CODE_ROUTER, 1'b0); send_byte(8'(ADDR_LEN), 1'b0);
      send_byte(8'h00, 1'b0);       send_byte(8'h00, 1'b0);
      // Message type and DNS server, closed by the end code.
      send_byte(CODE_TYPE, 1'b1);   send_byte(8'(TYPE_LEN), 1'b0);
      send_byte(8'hFF, 1'b0);       send_byte(CODE_DNS, 1'b0);
      send_byte(8'(ADDR_LEN), 1'b0); send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);       send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b0);       send_byte(CODE_END, 1'b0);
      // Wrong length, a length past the area, an unknown code, an empty packet.
      send_byte(CODE_SERVER, 1'b1); send_byte(8'd5, 1'b0);
      send_byte(CODE_LEASE, 1'b1);  send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(CODE_END, 1'b1);
      drain_results();

      // Random packets; every dozen the sender waits for the results to drain.
      while (parsed_bytes < BYTE_GOAL) begin
         steady = ($urandom_range(0, 5) == 0);
         build_packet();
         foreach (pkt[i]) send_byte(pkt[i][7:0], pkt[i][8]);
         packets_sent++;
         if (packets_sent % 12 == 0) begin
            drain_results();
         end
      end

      // Drain, then leave room for any unexpected late result.
      drain_results();
      repeat (8) @(negedge clock);

      $display("Covered %0d random packets and %0d parsed option bytes.",
               packets_sent, parsed_bytes);
      $display("Results by status: %0d ok, %0d out of area, %0d bad length, %0d unknown code.",
               board.status_count[ST_OK], board.status_count[ST_BOUNDS],
               board.status_count[ST_LENGTH], board.status_count[ST_UNKNOWN]);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
